/* rtl/sbip_pkg.sv */
`default_nettype none
package sbip_pkg;

	// table geometry
	localparam int SCHEME_COUNT      = 32;
	localparam int SCHEME_W          = 5;
	localparam int POINTS_PER_SCHEME = 256;
	localparam int POINT_W           = 8;
	localparam int ADDR_W            = SCHEME_W + POINT_W;
	localparam int TABLE_DEPTH       = SCHEME_COUNT * POINTS_PER_SCHEME;
	localparam int BIT_COUNT_WIDTH   = 24;

	// data widths
	localparam int SNR_W = 16;
	localparam int BER_W = 32;
	localparam int ENT_W = BER_W + 1;   // written flag on top of the BER
	localparam int NUM_W = 49;          // interpolation numerator
	localparam int STP_W = 6;           // divider step counter

	// opcodes
	localparam logic [1:0] OP_WR_POINT = 2'd0;
	localparam logic [1:0] OP_WR_DESC  = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	// divider request
	typedef struct packed {
		logic             load;
		logic [STP_W-1:0] steps;
	} div_req_t;

endpackage
`default_nettype wire

/* rtl/sbip_ram.sv */
`default_nettype none
module sbip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/sbip_div.sv */
`default_nettype none
module sbip_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sbip_pkg::div_req_t         req,
	input  wire logic [sbip_pkg::NUM_W-1:0] dividend,
	input  wire logic [sbip_pkg::SNR_W-1:0] divisor,
	output logic                            done,
	output logic      [sbip_pkg::NUM_W-1:0] quot,
	output logic      [sbip_pkg::SNR_W-1:0] rem
);

	logic                            run_q;
	logic [sbip_pkg::STP_W-1:0]      cnt_q;
	logic [sbip_pkg::NUM_W-1:0]      dq_q;
	logic [sbip_pkg::SNR_W-1:0]      rem_q;
	logic [sbip_pkg::SNR_W-1:0]      dvs_q;
	logic                            done_q;
	logic [sbip_pkg::SNR_W:0]        trial;
	logic [sbip_pkg::SNR_W:0]        diff;
	logic                            qbit;

	// restoring step: one quotient bit a cycle
	assign trial = {rem_q, dq_q[sbip_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == sbip_pkg::STP_W'(1));
			if (req.load) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - sbip_pkg::STP_W'(1);
				if (cnt_q == sbip_pkg::STP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.load) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[sbip_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[sbip_pkg::SNR_W-1:0] : trial[sbip_pkg::SNR_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dq_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

/* rtl/snr_to_ber_interpolated_psr.sv */
`default_nettype none
// SNR to BER lookup with chunk success rate, 32 schemes of 256 grid points.
// Grid points and scheme descriptors are written straight from the request
// ports. An interpolated query runs a 16-step division for the grid index,
// two table reads, two multiplies, a 49-step division for the rounded
// weighted mean, then a square and a multiply per bit of the 24-bit count
// for the success rate, all on one shared multiplier and one bit-serial
// divider; a clamped query goes straight to the success rate. The result
// appears on the output ports for one cycle with done high; it cannot be
// held off, so capture it then. After reset all 8192 entries of the point
// table are cleared with busy high; spacing writes are taken throughout.
module snr_to_ber_interpolated_psr (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [4:0]  scheme_index,
	input  wire logic [7:0]  point_index,
	input  wire logic [31:0] point_ber,
	input  wire logic signed [15:0] range_low_snr,
	input  wire logic signed [15:0] range_high_snr,
	input  wire logic [31:0] ber_at_low,
	input  wire logic [31:0] ber_at_high,
	input  wire logic signed [15:0] query_snr,
	input  wire logic [23:0] bit_count,
	output logic             done,
	output logic [31:0]      ber_out,
	output logic [31:0]      success_rate,
	output logic             missing_point
);

	typedef enum logic [13:0] {
		S_CLR  = 14'b00000000000001,
		S_IDLE = 14'b00000000000010,
		S_CMP  = 14'b00000000000100,
		S_DIVK = 14'b00000000001000,
		S_RD0  = 14'b00000000010000,
		S_CHK0 = 14'b00000000100000,
		S_RD1  = 14'b00000001000000,
		S_CHK1 = 14'b00000010000000,
		S_MULA = 14'b00000100000000,
		S_MULB = 14'b00001000000000,
		S_DIVN = 14'b00010000000000,
		S_POWS = 14'b00100000000000,
		S_POWA = 14'b01000000000000,
		S_POWB = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [15:0] spacing_q;
	logic [15:0] sp;

	logic signed [15:0] lo_snr_q [sbip_pkg::SCHEME_COUNT];
	logic signed [15:0] hi_snr_q [sbip_pkg::SCHEME_COUNT];
	logic [31:0]        lo_ber_q [sbip_pkg::SCHEME_COUNT];
	logic [31:0]        hi_ber_q [sbip_pkg::SCHEME_COUNT];

	logic [sbip_pkg::ADDR_W-1:0]   clr_q;
	logic [sbip_pkg::SCHEME_W-1:0] sc_q;
	logic [sbip_pkg::POINT_W-1:0]  pidx_q;
	logic signed [15:0]            snr_q;
	logic [sbip_pkg::BIT_COUNT_WIDTH-1:0] n_q;
	logic [15:0]                   r_q;
	logic [31:0]                   p0_q;
	logic [31:0]                   p1_q;
	logic [47:0]                   pa_q;
	logic [31:0]                   ber_q;
	logic [31:0]                   base_q;
	logic [31:0]                   acc_q;
	logic                          have_q;

	logic        done_q;
	logic [31:0] ber_out_q;
	logic [31:0] succ_q;
	logic        miss_q;

	logic accept;

	// table memory
	logic                        ram_we;
	logic [sbip_pkg::ADDR_W-1:0] ram_waddr;
	logic [sbip_pkg::ENT_W-1:0]  ram_wdata;
	logic [sbip_pkg::ENT_W-1:0]  ram_rdata;

	// divider
	sbip_pkg::div_req_t          div_req;
	logic [sbip_pkg::NUM_W-1:0]  div_dividend;
	logic                        div_done;
	logic [sbip_pkg::NUM_W-1:0]  div_quot;
	logic [15:0]                 div_rem;

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] mul_rnd;
	logic [31:0] qm;

	logic signed [16:0] dsnr;
	logic [48:0]        num;
	logic [sbip_pkg::BIT_COUNT_WIDTH-1:0] n_shr;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign sp     = (spacing_q == 16'd0) ? 16'd1 : spacing_q;

	// spacing register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 16'd256;
		end else if (cfg_we) begin
			spacing_q <= cfg_wdata;
		end
	end

	// scheme descriptors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbip_pkg::SCHEME_COUNT; i++) begin
				lo_snr_q[i] <= '0;
				hi_snr_q[i] <= '0;
				lo_ber_q[i] <= '0;
				hi_ber_q[i] <= '0;
			end
		end else if (accept && (opcode == sbip_pkg::OP_WR_DESC)) begin
			lo_snr_q[scheme_index] <= range_low_snr;
			hi_snr_q[scheme_index] <= range_high_snr;
			lo_ber_q[scheme_index] <= ber_at_low;
			hi_ber_q[scheme_index] <= ber_at_high;
		end
	end

	// point writes, or clearing sweep after reset
	always_comb begin
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = accept && (opcode == sbip_pkg::OP_WR_POINT);
			ram_waddr = {scheme_index, point_index};
			ram_wdata = {1'b1, point_ber};
		end
	end

	sbip_ram #(
		.WIDTH(sbip_pkg::ENT_W),
		.DEPTH(sbip_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr({sc_q, pidx_q}),
		.rdata(ram_rdata)
	);

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_MULA: begin
				mul_a = p0_q;
				mul_b = {16'd0, sp - r_q};
			end
			S_MULB: begin
				mul_a = p1_q;
				mul_b = {16'd0, r_q};
			end
			S_POWA: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = base_q;
				mul_b = base_q;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign mul_rnd = mul_p + 64'h0000_0000_8000_0000;
	assign qm      = mul_rnd[63:32];

	assign dsnr  = 17'(snr_q) - 17'(lo_snr_q[sc_q]);
	assign num   = 49'(pa_q) + 49'(mul_p[47:0]) + 49'(sp >> 1);
	assign n_shr = n_q >> 1;

	// divider requests: grid index, then rounded mean
	always_comb begin
		div_req      = '0;
		div_dividend = {dsnr[15:0], 33'd0};
		if ((state_q == S_CMP) && (snr_q > lo_snr_q[sc_q]) && (snr_q < hi_snr_q[sc_q])) begin
			div_req.load  = 1'b1;
			div_req.steps = sbip_pkg::STP_W'(16);
		end else if (state_q == S_MULB) begin
			div_req.load  = 1'b1;
			div_req.steps = sbip_pkg::STP_W'(sbip_pkg::NUM_W);
			div_dividend  = num;
		end
	end

	sbip_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.dividend(div_dividend),
		.divisor (sp),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + sbip_pkg::ADDR_W'(1);
					if (clr_q == {sbip_pkg::ADDR_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && (opcode == sbip_pkg::OP_QUERY)) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (snr_q <= lo_snr_q[sc_q]) begin
						state_q <= S_POWS;
					end else if (snr_q >= hi_snr_q[sc_q]) begin
						state_q <= S_POWS;
					end else begin
						state_q <= S_DIVK;
					end
				end
				S_DIVK: begin
					if (div_done) begin
						if (div_quot[15:8] != 8'd0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD0;
						end
					end
				end
				S_RD0: state_q <= S_CHK0;
				S_CHK0: begin
					if (!ram_rdata[32]) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (r_q == 16'd0) begin
						state_q <= S_POWS;
					end else if (pidx_q == {sbip_pkg::POINT_W{1'b1}}) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_CHK1;
				S_CHK1: begin
					if (!ram_rdata[32]) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MULA;
					end
				end
				S_MULA: state_q <= S_MULB;
				S_MULB: state_q <= S_DIVN;
				S_DIVN: begin
					if (div_done) begin
						state_q <= S_POWS;
					end
				end
				S_POWS: begin
					if ((ber_q == 32'd0) || (n_q == '0)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_POWA;
					end
				end
				S_POWA: begin
					if (n_shr == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_POWB;
					end
				end
				S_POWB: state_q <= S_POWA;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sc_q  <= scheme_index;
				snr_q <= query_snr;
				n_q   <= bit_count;
			end
			S_CMP: begin
				if (snr_q <= lo_snr_q[sc_q]) begin
					ber_q <= lo_ber_q[sc_q];
				end else begin
					ber_q <= hi_ber_q[sc_q];
				end
			end
			S_DIVK: begin
				pidx_q    <= div_quot[7:0];
				r_q       <= div_rem;
				ber_out_q <= '0;
				succ_q    <= '0;
				miss_q    <= 1'b1;
			end
			S_CHK0: begin
				ber_q  <= ram_rdata[31:0];
				p0_q   <= ram_rdata[31:0];
				pidx_q <= pidx_q + sbip_pkg::POINT_W'(1);
			end
			S_CHK1: p1_q <= ram_rdata[31:0];
			S_MULA: pa_q <= mul_p[47:0];
			S_DIVN: ber_q <= div_quot[31:0];
			S_POWS: begin
				base_q    <= 32'd0 - ber_q;
				have_q    <= 1'b0;
				ber_out_q <= ber_q;
				succ_q    <= 32'hFFFF_FFFF;
				miss_q    <= 1'b0;
			end
			S_POWA: begin
				if (n_q[0]) begin
					acc_q  <= have_q ? qm : base_q;
					succ_q <= have_q ? qm : base_q;
					have_q <= 1'b1;
				end else begin
					succ_q <= acc_q;
				end
				n_q <= n_shr;
			end
			S_POWB: base_q <= qm;
			default: ;
		endcase
	end

	assign done          = done_q;
	assign ber_out       = ber_out_q;
	assign success_rate  = succ_q;
	assign missing_point = miss_q;

endmodule
`default_nettype wire

/* rtl/sbip_checker.sv */
`default_nettype none
module sbip_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  opcode,
	input wire logic        done,
	input wire logic [31:0] ber_out,
	input wire logic [31:0] success_rate,
	input wire logic        missing_point
);

	// result comes with the block back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// results are single-cycle pulses
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result repeated");

	// a missing point zeroes the numbers
	a_missing: assert property (@(posedge clk) disable iff (!arst_n)
		done && missing_point |-> (ber_out == 32'd0) && (success_rate == 32'd0))
		else $error("missing point with data");

	// zero BER means certain success
	a_zero_ber: assert property (@(posedge clk) disable iff (!arst_n)
		done && !missing_point && (ber_out == 32'd0) |-> (success_rate == 32'hFFFF_FFFF))
		else $error("zero BER without full success");

	// load requests give no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode != sbip_pkg::OP_QUERY) |=> !done)
		else $error("result after load request");

endmodule

bind snr_to_ber_interpolated_psr sbip_checker u_sbip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.opcode       (opcode),
	.done         (done),
	.ber_out      (ber_out),
	.success_rate (success_rate),
	.missing_point(missing_point)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, ignored by the block
	localparam int IDLE_LIMIT = 40000;        // covers the clear of all 8192 table entries
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [1:0]         op;
		logic [4:0]         sc;
		logic [7:0]         pi;
		logic [31:0]        pber;
		logic signed [15:0] rlo;
		logic signed [15:0] rhi;
		logic [31:0]        blo;
		logic [31:0]        bhi;
		logic signed [15:0] qs;
		logic [23:0]        bc;
	} req_t;

	typedef struct {
		logic [31:0] ber;
		logic [31:0] psr;
		logic        miss;
	} ans_t;

	logic clk, arst_n, cfg_we, start, busy, done, missing_point;
	logic [15:0] cfg_wdata;
	logic [1:0] opcode;
	logic [4:0] scheme_index;
	logic [7:0] point_index;
	logic [31:0] point_ber, ber_at_low, ber_at_high, ber_out, success_rate;
	logic signed [15:0] range_low_snr, range_high_snr, query_snr;
	logic [23:0] bit_count;

	snr_to_ber_interpolated_psr uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .opcode(opcode), .scheme_index(scheme_index),
		.point_index(point_index), .point_ber(point_ber),
		.range_low_snr(range_low_snr), .range_high_snr(range_high_snr),
		.ber_at_low(ber_at_low), .ber_at_high(ber_at_high), .query_snr(query_snr),
		.bit_count(bit_count), .done(done), .ber_out(ber_out),
		.success_rate(success_rate), .missing_point(missing_point)
	);

	// shadow of the block's tables and spacing register
	logic [31:0] grid_ber [sbip_pkg::TABLE_DEPTH];
	bit          grid_set [sbip_pkg::TABLE_DEPTH];
	int          edge_lo_snr [sbip_pkg::SCHEME_COUNT];
	int          edge_hi_snr [sbip_pkg::SCHEME_COUNT];
	logic [31:0] edge_lo_ber [sbip_pkg::SCHEME_COUNT];
	logic [31:0] edge_hi_ber [sbip_pkg::SCHEME_COUNT];
	int unsigned grid_step;

	ans_t pending_answers [$];
	int errors, n_sent, n_answers, n_missing, n_interp, wd_count;
	bit calm;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
	endtask

	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b) + 64'h8000_0000;
		return p[63:32];
	endfunction

	// (1 - ber)^n by square-and-multiply, exponent bits from the bottom up
	function automatic logic [31:0] chunk_success(input logic [31:0] ber, input logic [23:0] n);
		logic [31:0] base, acc;
		bit have;
		logic [23:0] e;
		if (ber == 0 || n == 0) return 32'hFFFF_FFFF;
		base = 32'(33'h1_0000_0000 - 33'(ber));
		acc = 0;
		have = 0;
		e = n;
		while (e != 0) begin
			if (e[0]) begin
				acc = have ? qmul(acc, base) : base;
				have = 1;
			end
			e = e >> 1;
			if (e != 0) base = qmul(base, base);
		end
		return acc;
	endfunction

	// apply one request to the shadow state; returns 1 when a result is due
	function automatic bit apply_request(input req_t r, output ans_t a);
		int s, lo, hi, addr;
		int unsigned sp, d, k, rem;
		logic [63:0] num;
		a = '{ber: 0, psr: 0, miss: 0};
		case (r.op)
			sbip_pkg::OP_WR_POINT: begin
				addr = r.sc * sbip_pkg::POINTS_PER_SCHEME + r.pi;
				grid_ber[addr] = r.pber;
				grid_set[addr] = 1;
				return 0;
			end
			sbip_pkg::OP_WR_DESC: begin
				edge_lo_snr[r.sc] = r.rlo;
				edge_hi_snr[r.sc] = r.rhi;
				edge_lo_ber[r.sc] = r.blo;
				edge_hi_ber[r.sc] = r.bhi;
				return 0;
			end
			sbip_pkg::OP_QUERY: begin
				s = r.qs;
				lo = edge_lo_snr[r.sc];
				hi = edge_hi_snr[r.sc];
				if (s <= lo) begin
					a.ber = edge_lo_ber[r.sc];
				end else if (s >= hi) begin
					a.ber = edge_hi_ber[r.sc];
				end else begin
					sp = (grid_step == 0) ? 1 : grid_step;
					d = s - lo;
					k = d / sp;
					rem = d % sp;
					addr = r.sc * sbip_pkg::POINTS_PER_SCHEME + k;
					if (k >= sbip_pkg::POINTS_PER_SCHEME || !grid_set[addr]) begin
						a.miss = 1;
					end else if (rem == 0) begin
						a.ber = grid_ber[addr];
					end else if (k + 1 >= sbip_pkg::POINTS_PER_SCHEME ||
							!grid_set[addr + 1]) begin
						a.miss = 1;
					end else begin
						num = 64'(sp - rem) * 64'(grid_ber[addr]) +
							64'(rem) * 64'(grid_ber[addr + 1]) + 64'(sp / 2);
						a.ber = 32'(num / 64'(sp));
						n_interp++;
					end
				end
				if (!a.miss) a.psr = chunk_success(a.ber, r.bc);
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic req_t random_request();
		req_t r;
		r.op = 2'($urandom);
		r.sc = 5'($urandom);
		r.pi = 8'($urandom);
		r.pber = $urandom;
		r.rlo = 16'($urandom);
		r.rhi = 16'($urandom);
		r.blo = $urandom;
		r.bhi = $urandom;
		r.qs = 16'($urandom);
		r.bc = 24'($urandom);
		return r;
	endfunction

	// BER values biased small so success rates stay interesting
	function automatic logic [31:0] random_ber();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(8, 31);
			default: return $urandom >> $urandom_range(16, 28);
		endcase
	endfunction

	function automatic logic [23:0] random_bits();
		return $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 2000));
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	// send one request; start stays high between back-to-back requests
	task automatic send_request(input req_t r);
		ans_t a;
		int gap;
		if (!calm && $urandom_range(0, 99) < 26) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		opcode <= r.op;
		scheme_index <= r.sc;
		point_index <= r.pi;
		point_ber <= r.pber;
		range_low_snr <= r.rlo;
		range_high_snr <= r.rhi;
		ber_at_low <= r.blo;
		ber_at_high <= r.bhi;
		query_snr <= r.qs;
		bit_count <= r.bc;
		do @(posedge clk); while (busy);
		n_sent++;
		if (apply_request(r, a)) pending_answers.insert(pending_answers.size(), a);
	endtask

	task automatic write_point(input int sc, input int pi, input logic [31:0] b);
		req_t r;
		r = random_request();
		r.op = sbip_pkg::OP_WR_POINT; r.sc = 5'(sc); r.pi = 8'(pi); r.pber = b;
		send_request(r);
	endtask

	task automatic write_desc(input int sc, input int lo, input int hi,
			input logic [31:0] blo, input logic [31:0] bhi);
		req_t r;
		r = random_request();
		r.op = sbip_pkg::OP_WR_DESC; r.sc = 5'(sc); r.rlo = clamp16(lo); r.rhi = clamp16(hi);
		r.blo = blo; r.bhi = bhi;
		send_request(r);
	endtask

	task automatic query(input int sc, input int snr, input logic [23:0] bc);
		req_t r;
		r = random_request();
		r.op = sbip_pkg::OP_QUERY; r.sc = 5'(sc); r.qs = clamp16(snr); r.bc = bc;
		send_request(r);
	endtask

	// spacing changes only once the block has gone quiet
	task automatic set_spacing(input logic [15:0] v);
		@(negedge clk);
		start <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 16'($urandom);
		grid_step = v;
	endtask

	// result check: one answer per done strobe
	always @(posedge clk) begin
		ans_t e;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				flag_error("result with no query outstanding");
			end else begin
				e = pending_answers.pop_front();
				n_answers++;
				if (e.miss) n_missing++;
				if (ber_out !== e.ber || success_rate !== e.psr || missing_point !== e.miss)
					flag_error($sformatf("exp ber %h psr %h miss %b, got ber %h psr %h miss %b",
						e.ber, e.psr, e.miss, ber_out, success_rate, missing_point));
			end
		end
	end

	// watchdog on cycles with no request accepted and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			wd_count <= 0;
		end else if (wd_count >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			wd_count <= wd_count + 1;
		end
	end

	// edges, grid hits, interpolation, missing points, inverted range, unused opcode
	task automatic test_directed();
		req_t r;
		write_desc(0, 0, 10 * 256, 32'h0100_0000, 32'h0000_0010);
		for (int i = 0; i <= 10; i++) write_point(0, i, 32'h0100_0000 >> i);
		query(0, -32768, 24'd100);
		query(0, 0, 24'd1);
		query(0, 10 * 256, 24'hFF_FFFF);
		query(0, 32767, 24'd0);
		query(0, 3 * 256, 24'd1000);
		query(0, 3 * 256 + 77, 24'd1000);
		query(0, 9 * 256 + 255, 24'hFF_FFFF);
		write_point(0, 4, 32'hFFFF_FFFF);
		query(0, 4 * 256, 24'd3);
		write_point(0, 5, 32'h0);
		query(0, 5 * 256, 24'd12345);
		write_desc(1, -32768, 32767, 32'hFFFF_FFFF, 32'h0);
		query(1, 100, 24'd5);
		write_desc(2, 500, -500, 32'h1234_5678, 32'h8765_4321);
		query(2, 0, 24'd7);
		query(2, 501, 24'd7);
		r = random_request();
		r.op = OP_NONE;
		send_request(r);
		write_point(31, 255, 32'hAAAA_5555);
	endtask

	// random well-formed tables with queries, mixed with noise requests
	task automatic test_random_tables(input int count);
		int stop, sc, npts, lo, hi, sp, span, margin, skip;
		stop = n_sent + count;
		sp = (grid_step == 0) ? 1 : grid_step;
		while (n_sent < stop) begin
			if ($urandom_range(0, 99) < 15) begin
				send_request(random_request());
				continue;
			end
			sc = $urandom_range(0, sbip_pkg::SCHEME_COUNT - 1);
			npts = $urandom_range(2, 12);
			lo = $urandom_range(0, 65535) - 32768;
			hi = lo + (npts - 1) * sp;
			if ($urandom_range(0, 9) == 0) hi = lo - $urandom_range(0, 300);
			write_desc(sc, lo, hi, random_ber(), random_ber());
			lo = clamp16(lo);
			hi = clamp16(hi);
			skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, npts - 1) : -1;
			for (int i = 0; i < npts; i++)
				if (i != skip) write_point(sc, i, random_ber());
			span = (hi > lo) ? hi - lo : 0;
			margin = (sp < 300) ? sp : 300;
			repeat ($urandom_range(3, 10))
				query(sc, lo - margin + $urandom_range(0, span + 2 * margin), random_bits());
		end
	endtask

	initial begin
		logic [15:0] spacings [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		opcode = '0;
		scheme_index = '0;
		point_index = '0;
		point_ber = '0;
		range_low_snr = '0;
		range_high_snr = '0;
		ber_at_low = '0;
		ber_at_high = '0;
		query_snr = '0;
		bit_count = '0;
		grid_step = 256;
		errors = 0; n_sent = 0; n_answers = 0; n_missing = 0; n_interp = 0;
		calm = 0;
		for (int i = 0; i < sbip_pkg::TABLE_DEPTH; i++) begin
			grid_ber[i] = '0;
			grid_set[i] = 0;
		end
		for (int i = 0; i < sbip_pkg::SCHEME_COUNT; i++) begin
			edge_lo_snr[i] = 0; edge_hi_snr[i] = 0;
			edge_lo_ber[i] = '0; edge_hi_ber[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		spacings = '{16'd256, 16'd1, 16'd0, 16'd65535, 16'd37, 16'($urandom_range(2, 2000))};
		foreach (spacings[i]) begin
			set_spacing(spacings[i]);
			calm = (i == 2);
			test_random_tables(250);
		end
		calm = 0;

		@(negedge clk);
		start <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over six spacing settings; %0d results checked",
			n_sent, n_answers);
		$display("(%0d interpolated, %0d missing-point answers)", n_interp, n_missing);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors in total", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/sbip_pkg.sv
rtl/sbip_ram.sv
rtl/sbip_div.sv
rtl/snr_to_ber_interpolated_psr.sv
rtl/sbip_checker.sv
verif/tb.sv
